FILE: rtl/brush_falloff_weight_macros.svh
// Assertion macros for the brush falloff weight block
`ifndef BRUSH_FALLOFF_WEIGHT_MACROS_SVH
`define BRUSH_FALLOFF_WEIGHT_MACROS_SVH
`ifndef SYNTHESIS
`define BFW_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BFW_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFW_ASSERT(label, clk, rst, prop, msg)
`define BFW_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: rtl/bfw_pkg.sv
// Shared types and constants for the brush falloff weight block
package bfw_pkg;

  localparam int unsigned SqrtSteps = 25;   // root bits of a 50-bit sum of squares
  localparam int unsigned DivSteps  = 16;   // fraction bits of the falloff ratio
  localparam int unsigned DotBits   = 15;   // quotient bits of the cosine divide

  typedef enum logic [1:0] {
    CFG_FALLOFF  = 2'd0,
    CFG_STRENGTH = 2'd1
  } cfg_addr_t;

  // word carried through the root and divide stages
  typedef struct packed {
    logic [49:0] rsq;      // remainder of the square root
    logic [24:0] root;     // partial root
    logic [41:0] numa;     // |offset . normal|
    logic        kill;     // weight forced to zero
    logic        in_core;  // within the inner radius
    logic        asat;     // cosine quotient saturates
    logic [15:0] inner;
    logic [16:0] span;
    logic [16:0] urem;
    logic [15:0] u;
    logic [41:0] arem;
    logic [14:0] aq;
  } pipe_t;

endpackage

FILE: rtl/bfw_if.sv
// Channel interfaces: voxel words in, weight words out, register writes
interface bfw_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] voxel_x;
  logic signed [15:0] voxel_y;
  logic signed [15:0] voxel_z;
  logic signed [23:0] centre_x;
  logic signed [23:0] centre_y;
  logic signed [23:0] centre_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic        [15:0] brush_radius;
  modport source (output valid, voxel_x, voxel_y, voxel_z, centre_x, centre_y, centre_z,
                  normal_x, normal_y, normal_z, brush_radius, input ready);
  modport sink (input valid, voxel_x, voxel_y, voxel_z, centre_x, centre_y, centre_z,
                normal_x, normal_y, normal_z, brush_radius, output ready);
endinterface

interface bfw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] weight;
  modport source (output valid, weight, input ready);
  modport sink (input valid, weight, output ready);
endinterface

interface bfw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [16:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

FILE: rtl/brush_falloff_weight.sv
// Top level: pipelined smoothstep brush falloff weight
//
//  channel  dir  word
//  in       in   voxel position, brush centre, normal, radius
//  out      out  weight, unsigned Q8.8
//  cfg      in   addr 0 falloff_fraction, addr 1 tool_strength
//
// One voxel per cycle while the output is not stalled; 3 input stages, 25 square root
// stages (one root bit each), one setup stage, 16 divide stages (one falloff
// bit each, one cosine bit in the first 15), 3 smoothstep/multiply stages,
// output register.
// rst is synchronous and clears all valid bits and the cfg registers to defaults.
// The whole pipeline holds while the output word waits; nothing is lost.
`include "brush_falloff_weight_macros.svh"

module brush_falloff_weight (
  input  logic clk,
  input  logic rst,
  bfw_in_if.sink    in,
  bfw_out_if.source out,
  bfw_cfg_if.sink   cfg
);

  logic [16:0] falloff_fraction;
  logic [15:0] tool_strength;
  logic        adv;
  logic        o_v;
  logic [15:0] o_w;

  assign adv      = !o_v || out.ready;
  assign in.ready = adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      falloff_fraction <= 17'd32768;
      tool_strength    <= 16'd256;
    end else if (cfg.valid) begin
      case (cfg.addr)
        bfw_pkg::CFG_FALLOFF:  falloff_fraction <= cfg.data;
        bfw_pkg::CFG_STRENGTH: tool_strength <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // stage A: offsets
  logic               a_v;
  logic signed [24:0] a_d [3];
  logic signed [15:0] a_n [3];
  logic        [15:0] a_rad;

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (adv) a_v <= in.valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_d[0] <= {in.voxel_x[15], in.voxel_x, 8'd0} - {in.centre_x[23], in.centre_x};
      a_d[1] <= {in.voxel_y[15], in.voxel_y, 8'd0} - {in.centre_y[23], in.centre_y};
      a_d[2] <= {in.voxel_z[15], in.voxel_z, 8'd0} - {in.centre_z[23], in.centre_z};
      a_n[0] <= in.normal_x;
      a_n[1] <= in.normal_y;
      a_n[2] <= in.normal_z;
      a_rad  <= in.brush_radius;
    end
  end

  // stage B: squares, dot terms, inner radius
  logic               b_v;
  logic        [49:0] b_sq [3];
  logic signed [40:0] b_p [3];
  logic        [15:0] b_rad;
  logic        [15:0] b_inner;
  logic        [16:0] f_cl;
  logic        [16:0] f_rest;
  logic        [32:0] inner_prod;
  logic signed [49:0] sq_full [3];

  assign f_cl       = falloff_fraction[16] ? 17'd65536 : falloff_fraction;
  assign f_rest     = 17'd65536 - f_cl;
  assign inner_prod = {17'd0, a_rad} * {16'd0, f_rest};

  always_comb begin
    for (int i = 0; i < 3; i++) sq_full[i] = a_d[i] * a_d[i];
  end

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (adv) b_v <= a_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_sq[i] <= sq_full[i][49:0];
        b_p[i]  <= a_d[i] * a_n[i];
      end
      b_rad   <= a_rad;
      b_inner <= inner_prod[31:16];
    end
  end

  // stage C: sums, special cases -> head of root pipeline
  localparam int unsigned SQV = bfw_pkg::SqrtSteps + 1;
  logic               sq_v [SQV];
  bfw_pkg::pipe_t     sq [SQV];
  logic        [49:0] sumsq;
  logic signed [41:0] num;
  bfw_pkg::pipe_t     c_word;

  always_comb begin
    sumsq = b_sq[0] + b_sq[1] + b_sq[2];
    num   = 42'(b_p[0]) + 42'(b_p[1]) + 42'(b_p[2]);
    c_word        = '0;
    c_word.rsq    = sumsq;
    c_word.numa   = 42'(-num);
    c_word.kill   = (sumsq == '0) || (b_rad == '0) || (num > 0);
    c_word.inner  = b_inner;
    c_word.span   = {1'b0, b_rad} - {1'b0, b_inner};
  end

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (adv) sq_v[0] <= b_v;
  end
  always_ff @(posedge clk) begin
    if (adv) sq[0] <= c_word;
  end

  // square root: one root bit per stage, MSB first
  for (genvar g = 0; g < bfw_pkg::SqrtSteps; g++) begin : g_sqrt
    localparam int unsigned Bit = bfw_pkg::SqrtSteps - 1 - g;
    logic [50:0]    cand;
    bfw_pkg::pipe_t nxt;
    always_comb begin
      cand = (51'(sq[g].root) << (Bit + 1)) + (51'(1) << (2 * Bit));
      nxt  = sq[g];
      if ({1'b0, sq[g].rsq} >= cand) begin
        nxt.rsq       = 50'({1'b0, sq[g].rsq} - cand);
        nxt.root[Bit] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) sq_v[g+1] <= 1'b0;
      else if (adv) sq_v[g+1] <= sq_v[g];
    end
    always_ff @(posedge clk) begin
      if (adv) sq[g+1] <= nxt;
    end
  end

  // setup: inner test, band test, divide seeds
  localparam int unsigned DVV = bfw_pkg::DivSteps + 1;
  logic           dv_v [DVV];
  bfw_pkg::pipe_t dv [DVV];
  bfw_pkg::pipe_t x_word;
  logic [25:0]    dn;

  always_comb begin
    x_word         = sq[bfw_pkg::SqrtSteps];
    x_word.in_core = x_word.root < 25'(x_word.inner);
    dn             = {1'b0, x_word.root} - 26'(x_word.inner);
    x_word.asat    = x_word.numa >= (42'(x_word.root) << bfw_pkg::DotBits);
    x_word.arem    = x_word.numa;
    x_word.aq      = '0;
    x_word.u       = '0;
    x_word.urem    = 17'(dn[15:0]);
    if (!x_word.in_core && (dn >= 26'(x_word.span))) x_word.kill = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (adv) dv_v[0] <= sq_v[bfw_pkg::SqrtSteps];
  end
  always_ff @(posedge clk) begin
    if (adv) dv[0] <= x_word;
  end

  // divides: falloff fraction bit per stage, cosine bit in all but the last stage
  for (genvar g = 0; g < bfw_pkg::DivSteps; g++) begin : g_div
    localparam int unsigned QBit = (g < bfw_pkg::DotBits) ? bfw_pkg::DotBits - 1 - g : 0;
    logic [16:0]    r2;
    logic [41:0]    dsh;
    bfw_pkg::pipe_t nxt;
    always_comb begin
      nxt = dv[g];
      r2  = {dv[g].urem[15:0], 1'b0};
      dsh = '0;
      if (r2 >= dv[g].span) begin
        nxt.urem = r2 - dv[g].span;
        nxt.u[bfw_pkg::DivSteps-1-g] = 1'b1;
      end else begin
        nxt.urem = r2;
      end
      if (g < bfw_pkg::DotBits) begin
        dsh = 42'(dv[g].root) << QBit;
        if (dv[g].arem >= dsh) begin
          nxt.arem = dv[g].arem - dsh;
          nxt.aq[QBit] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv_v[g+1] <= 1'b0;
      else if (adv) dv_v[g+1] <= dv_v[g];
    end
    always_ff @(posedge clk) begin
      if (adv) dv[g+1] <= nxt;
    end
  end

  // T1: cosine clamp, t and t^2
  bfw_pkg::pipe_t dz;
  logic        t1_v, t1_kill, t1_inside;
  logic [16:0] t1_t, t1_t2;
  logic [14:0] t1_abs;
  logic [16:0] t_val;
  logic [33:0] tt;

  assign dz    = dv[bfw_pkg::DivSteps];
  assign t_val = 17'd65536 - {1'b0, dz.u};
  assign tt    = t_val * t_val;

  always_ff @(posedge clk) begin
    if (rst) t1_v <= 1'b0;
    else if (adv) t1_v <= dv_v[bfw_pkg::DivSteps];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t1_kill   <= dz.kill;
      t1_inside <= dz.in_core;
      t1_t      <= t_val;
      t1_t2     <= tt[32:16];
      t1_abs    <= (dz.asat || dz.aq > 15'd16384) ? 15'd16384 : dz.aq;
    end
  end

  // T2: smoothstep; inside the inner radius the factor is 1.0
  logic        t2_v, t2_kill;
  logic [16:0] t2_s;
  logic [14:0] t2_abs;
  logic [17:0] poly;
  logic [34:0] sp;

  assign poly = 18'd196608 - {t1_t, 1'b0};
  assign sp   = t1_t2 * poly;

  always_ff @(posedge clk) begin
    if (rst) t2_v <= 1'b0;
    else if (adv) t2_v <= t1_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t2_kill <= t1_kill;
      t2_abs  <= t1_abs;
      t2_s    <= t1_inside ? 17'd65536 : sp[32:16];
    end
  end

  // T3: strength * s
  logic        t3_v, t3_kill;
  logic [32:0] t3_m;
  logic [14:0] t3_abs;

  always_ff @(posedge clk) begin
    if (rst) t3_v <= 1'b0;
    else if (adv) t3_v <= t2_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t3_kill <= t2_kill;
      t3_abs  <= t2_abs;
      t3_m    <= tool_strength * t2_s;
    end
  end

  // T4 / output: times cosine, scale, saturate, zero when killed
  logic [47:0] prod;
  logic [17:0] wq;

  assign prod = t3_m * t3_abs;
  assign wq   = prod[47:30];

  always_ff @(posedge clk) begin
    if (rst) o_v <= 1'b0;
    else if (adv) o_v <= t3_v;
  end
  always_ff @(posedge clk) begin
    if (adv) o_w <= t3_kill ? 16'd0 : ((wq > 18'd65535) ? 16'hFFFF : wq[15:0]);
  end

  assign out.valid  = o_v;
  assign out.weight = o_w;

  `BFW_ASSERT(a_abs_range, clk, rst, t1_v |-> t1_abs <= 15'd16384, "cosine above one")
  `BFW_ASSERT(a_s_range, clk, rst, t2_v |-> t2_s <= 17'd65536, "smoothstep above one")
  `BFW_ASSERT(a_stall, clk, rst, (o_v && !out.ready) |-> !in.ready, "input taken during stall")
  `BFW_ASSERT(a_hold, clk, rst, (o_v && !out.ready) |=> (o_v && $stable(o_w)), "output word lost")

endmodule
